// ===== sv/hgc_pkg.sv =====
package hgc_pkg;

	// Default widths
	localparam int HEIGHT_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT_MIN = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT_MAX = 1'b1;

	// Segment codes; the last one selects white with a zero blend weight
	localparam logic [1:0] SEG_NAVY  = 2'd0;
	localparam logic [1:0] SEG_OCEAN = 2'd1;
	localparam logic [1:0] SEG_CYAN  = 2'd2;
	localparam logic [1:0] SEG_WHITE = 2'd3;

	// Gradient stops, entry 0 first: navy, ocean blue, cyan, white
	localparam logic [3:0][23:0] HGC_STOPS = {
		24'hFFFFFF, 24'h48CAE4, 24'h0096C7, 24'h001B44
	};

endpackage

// ===== sv/hgc_div_cell.sv =====
module hgc_div_cell #(
	parameter int DW = 16,
	parameter int FW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] rem_in,
	input  logic [DW-1:0] div_in,
	input  logic [FW-1:0] quo_in,
	input  logic [1:0]    seg_in,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] rem_out,
	output logic [DW-1:0] div_out,
	output logic [FW-1:0] quo_out,
	output logic [1:0]    seg_out
);
	import hgc_pkg::*;

	logic          valid_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [FW-1:0] quo_q;
	logic [1:0]    seg_q;
	logic [DW:0]   dbl;
	logic [DW:0]   diff;
	logic          take;

	// One restoring step: shift the remainder, subtract the divisor if it fits
	assign dbl  = {rem_in, 1'b0};
	assign diff = dbl - {1'b0, div_in};
	assign take = dbl >= {1'b0, div_in};

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q <= take ? diff[DW-1:0] : dbl[DW-1:0];
			div_q <= div_in;
			quo_q <= {quo_in[FW-2:0], take};
			seg_q <= seg_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign div_out   = div_q;
	assign quo_out   = quo_q;
	assign seg_out   = seg_q;

endmodule

// ===== sv/hgc_blend.sv =====
module hgc_blend #(
	parameter int FW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    seg,
	input  logic [FW-1:0] frac,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue
);
	import hgc_pkg::*;

	localparam int PW = FW + 9;

	logic [23:0]        lo_col;
	logic [23:0]        hi_col;
	logic [FW:0]        w_lo;
	logic [1:0]         seg_next;
	logic               valid_s1;
	logic               ready_s1;
	logic [2:0][PW-1:0] prod_lo_s1;
	logic [2:0][PW-1:0] prod_hi_s1;
	logic               valid_q;
	logic [2:0][7:0]    chan_q;
	logic [2:0][PW-1:0] sum;

	// Stop pair of the segment; the index wraps so white pairs with navy at weight 0
	assign seg_next = seg + 2'd1;
	assign lo_col   = HGC_STOPS[seg];
	assign hi_col   = HGC_STOPS[seg_next];
	assign w_lo     = {1'b1, {FW{1'b0}}} - {1'b0, frac};

	assign ready_s1 = !valid_q || out_ready;
	assign in_ready = !valid_s1 || ready_s1;

	// Stage 1: weighted products per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int c = 0; c < 3; c++) begin
				prod_lo_s1[c] <= PW'(lo_col[8*c +: 8]) * PW'(w_lo);
				prod_hi_s1[c] <= PW'(hi_col[8*c +: 8]) * PW'(frac);
			end
		end
	end

	// Stage 2: sum and drop the fraction
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = prod_lo_s1[c] + prod_hi_s1[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_s1) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			for (int c = 0; c < 3; c++) begin
				chan_q[c] <= sum[c][FW+7:FW];
			end
		end
	end

	assign out_valid = valid_q;
	assign red       = chan_q[2];
	assign green     = chan_q[1];
	assign blue      = chan_q[0];

endmodule

// ===== sv/height_gradient_colormap_core.sv =====
// Channel | Signals                          | Direction | Request
// --------+----------------------------------+-----------+------------------------------
// in      | in_valid, in_ready, height       | in        | one height
// out     | out_valid, out_ready, red/green/blue | out   | one color per height
// cfg     | cfg_wr_en, cfg_index, cfg_data   | in        | write height_min / height_max
//
// One request per cycle sustained while the output is not stalled; the stages in order are range setup,
// integer segment, one divider cell per fraction bit, then two blend stages.
// Every stage has its own valid bit and fills bubbles, so input keeps flowing
// while a finished color waits at the output register, until the pipeline is full.
// Reset clears the range registers to zero and empties the pipeline.
module height_gradient_colormap_core #(
	parameter int HEIGHT_BITS = hgc_pkg::HEIGHT_BITS_DEF,
	parameter int FRAC_BITS   = hgc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [hgc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [HEIGHT_BITS-1:0]              cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [HEIGHT_BITS-1:0]       height,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue
);
	import hgc_pkg::*;

	localparam int H = HEIGHT_BITS;
	localparam int F = FRAC_BITS;

	logic signed [H-1:0] hmin_q;
	logic signed [H-1:0] hmax_q;

	// Range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmin_q <= '0;
			hmax_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_HEIGHT_MIN: hmin_q <= cfg_data;
				CFG_HEIGHT_MAX: hmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: offset and span, flipped for a reversed range
	logic signed [H:0] n_raw, d_raw;
	logic              rev;
	logic              valid_s1, ready_s1;
	logic signed [H:0] n_s1, d_s1;
	logic              eq_s1;

	assign n_raw = (H+1)'(height) - (H+1)'(hmin_q);
	assign d_raw = (H+1)'(hmax_q) - (H+1)'(hmin_q);
	assign rev   = hmax_q < hmin_q;

	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			n_s1  <= rev ? -n_raw : n_raw;
			d_s1  <= rev ? -d_raw : d_raw;
			eq_s1 <= hmin_q == hmax_q;
		end
	end

	// Stage 2: clamp cases and integer part of 3n/d
	logic [H-1:0] n_u, d_u;
	logic [H+1:0] n3, d2, sub;
	logic         ge1, ge2;
	logic         valid_s2, ready_s2;
	logic [H-1:0] rem_s2, div_s2;
	logic [1:0]   seg_s2;
	logic [H-1:0] rem_n, div_n;
	logic [1:0]   seg_n;

	assign n_u = n_s1[H-1:0];
	assign d_u = d_s1[H-1:0];
	assign n3  = (H+2)'(n_u) + (H+2)'({n_u, 1'b0});
	assign d2  = (H+2)'({d_u, 1'b0});
	assign ge2 = n3 >= d2;
	assign ge1 = n3 >= (H+2)'(d_u);
	assign sub = ge2 ? d2 : (ge1 ? (H+2)'(d_u) : '0);

	always_comb begin
		rem_n = '0;
		div_n = H'(1);
		seg_n = SEG_NAVY;
		priority if (eq_s1) begin
			seg_n = SEG_OCEAN;
		end else if (n_s1 <= 0) begin
			seg_n = SEG_NAVY;
		end else if (n_s1 >= d_s1) begin
			seg_n = SEG_WHITE;
		end else begin
			rem_n = H'(n3 - sub);
			div_n = d_u;
			seg_n = ge2 ? SEG_CYAN : (ge1 ? SEG_OCEAN : SEG_NAVY);
		end
	end

	assign ready_s1 = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			rem_s2 <= rem_n;
			div_s2 <= div_n;
			seg_s2 <= seg_n;
		end
	end

	// Divider chain: one fraction bit per cell
	logic [F:0]        c_valid, c_ready;
	logic [H-1:0]      c_rem [F+1];
	logic [H-1:0]      c_div [F+1];
	logic [F-1:0]      c_quo [F+1];
	logic [1:0]        c_seg [F+1];

	assign c_valid[0] = valid_s2;
	assign ready_s2   = c_ready[0];
	assign c_rem[0]   = rem_s2;
	assign c_div[0]   = div_s2;
	assign c_quo[0]   = '0;
	assign c_seg[0]   = seg_s2;

	for (genvar i = 0; i < F; i++) begin : g_cell
		hgc_div_cell #(
			.DW (H),
			.FW (F)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.rem_in    (c_rem[i]),
			.div_in    (c_div[i]),
			.quo_in    (c_quo[i]),
			.seg_in    (c_seg[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.rem_out   (c_rem[i+1]),
			.div_out   (c_div[i+1]),
			.quo_out   (c_quo[i+1]),
			.seg_out   (c_seg[i+1])
		);
	end

	// Color blend
	hgc_blend #(
		.FW (F)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid[F]),
		.in_ready  (c_ready[F]),
		.seg       (c_seg[F]),
		.frac      (c_quo[F]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// ===== sim/height_gradient_colormap_core_test.sv =====
module height_gradient_colormap_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hgc_pkg::*;

	localparam int HB          = HEIGHT_BITS_DEF;
	localparam int FRAC        = FRAC_BITS_DEF;
	localparam longint FONE    = longint'(1) << FRAC;
	localparam int LATENCY     = FRAC_BITS_DEF + 4;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 75;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// DUT ports; the inputs are known from time zero
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]     cfg_index = CFG_HEIGHT_MIN;
	logic [HB-1:0]               cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [HB-1:0]        height = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [7:0]                  red;
	logic [7:0]                  green;
	logic [7:0]                  blue;

	// Shadow of the range registers
	logic signed [HB-1:0]        range_lo = '0;
	logic signed [HB-1:0]        range_hi = '0;

	logic signed [HB-1:0]        height_queue[$];
	color_t                      color_expected[$];
	int                          errors = 0;
	int                          cycle_count = 0;
	int                          send_gap = 0;
	int                          hold_left = 0;
	bit                          hold_request = 1'b0;
	bit                          sender_calm = 1'b0;
	bit                          receiver_calm = 1'b0;

	height_gradient_colormap_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.height    (height),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Blend of one 8-bit channel between two stops
	function automatic logic [7:0] mix_channel(longint a, longint b, longint f);
		return 8'((a * (FONE - f) + b * f) >> FRAC);
	endfunction

	// Expected color of one height under the current range
	function automatic color_t gradient_color(logic signed [HB-1:0] z);
		longint n, d, seg, idx, f;
		logic [23:0] a, b;
		color_t c;
		if (range_lo == range_hi) begin
			a = HGC_STOPS[SEG_OCEAN];
			b = a;
			f = 0;
		end else begin
			n = longint'(z) - longint'(range_lo);
			d = longint'(range_hi) - longint'(range_lo);
			// reversed range: gradient still runs from min to max
			if (d < 0) begin
				n = -n;
				d = -d;
			end
			if (n <= 0)
				seg = 0;
			else if (n >= d)
				seg = longint'(3) << FRAC;
			else
				seg = ((longint'(3) * n) << FRAC) / d;
			idx = seg >> FRAC;
			if (idx > longint'(SEG_CYAN))
				idx = longint'(SEG_CYAN);
			f = seg - (idx << FRAC);
			a = HGC_STOPS[idx];
			b = HGC_STOPS[idx + 1];
		end
		c.red   = mix_channel(a[23:16], b[23:16], f);
		c.green = mix_channel(a[15:8], b[15:8], f);
		c.blue  = mix_channel(a[7:0], b[7:0], f);
		return c;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Height biased toward the configured range and its edges
	function automatic logic signed [HB-1:0] draw_height(int lo, int hi);
		int a, b, r;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		r = $urandom_range(0, 99);
		if (r < 70)
			return HB'(a + int'($urandom_range(0, b - a)));
		else if (r < 85)
			return HB'(($urandom_range(0, 1) ? lo : hi) + int'($urandom_range(0, 4)) - 2);
		return HB'($urandom);
	endfunction

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d colors still expected", $time, color_expected.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Height driver
	always @(posedge clk or negedge arst_n) begin
		logic signed [HB-1:0] next_height;
		if (!arst_n) begin
			in_valid <= 1'b0;
			height   <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				color_expected.push_back(gradient_color(height));
			// load next request once the current one is gone
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (height_queue.size() > 0) begin
					next_height = height_queue.pop_front();
					in_valid <= 1'b1;
					height   <= next_height;
					send_gap = sender_calm ? 0 : idle_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Color monitor and output backpressure
	always @(posedge clk or negedge arst_n) begin
		color_t got, want;
		int gap;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {red, green, blue};
				if (color_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected color r=%02h g=%02h b=%02h",
						$time, got.red, got.green, got.blue);
				end else begin
					want = color_expected.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: color mismatch expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
							$time, want.red, want.green, want.blue,
							got.red, got.green, got.blue);
					end
				end
			end
			// long hold fills the pipeline and stalls the input side
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				gap = receiver_calm ? 0 : idle_length();
				if (gap > 0)
					hold_left = gap - 1;
				out_ready <= (gap == 0);
			end
		end
	end

	// Wait until every request has been sent and every color has come back
	task automatic drain();
		while (height_queue.size() != 0 || in_valid || color_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Program both range registers while the block is idle
	task automatic set_range(int lo, int hi);
		drain();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_HEIGHT_MIN;
		cfg_data  <= HB'(lo);
		@(posedge clk);
		range_lo = HB'(lo);
		cfg_index <= CFG_HEIGHT_MAX;
		cfg_data  <= HB'(hi);
		@(posedge clk);
		range_hi = HB'(hi);
		cfg_wr_en <= 1'b0;
		sender_calm   = ($urandom_range(0, 3) == 0);
		receiver_calm = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		int lo, hi;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset range is empty: every height maps to ocean blue
		height_queue.push_back(-16'sd32768);
		height_queue.push_back(16'sd32767);
		height_queue.push_back(16'sd0);

		// full range: ends, middle and segment boundaries
		set_range(-32768, 32767);
		height_queue.push_back(-16'sd32768);
		height_queue.push_back(16'sd32767);
		height_queue.push_back(16'sd0);
		height_queue.push_back(-16'sd1);
		height_queue.push_back(16'sd1);
		height_queue.push_back(-16'sd10923);
		height_queue.push_back(16'sd10922);
		height_queue.push_back(16'sd10923);
		height_queue.push_back(16'sd32766);

		// reversed range, heights inside and beyond both ends
		set_range(100, -100);
		height_queue.push_back(16'sd100);
		height_queue.push_back(-16'sd100);
		height_queue.push_back(16'sd0);
		height_queue.push_back(16'sd300);
		height_queue.push_back(-16'sd300);
		height_queue.push_back(16'sd50);

		// nonzero empty range
		set_range(7, 7);
		height_queue.push_back(16'sd7);
		height_queue.push_back(-16'sd32768);
		height_queue.push_back(16'sd32767);

		// exact segment boundaries, top end lands on white
		set_range(0, 3);
		height_queue.push_back(16'sd1);
		height_queue.push_back(16'sd2);
		height_queue.push_back(16'sd3);

		// random phases over several ranges
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin lo = -32768; hi = 32767; end
				1: begin lo = 32767; hi = -32768; end
				2: begin lo = int'($urandom_range(0, 65535)) - 32768; hi = lo; end
				3: begin lo = int'($urandom_range(0, 65534)) - 32768; hi = lo + 1; end
				4: begin lo = -32768; hi = -32765; end
				6: begin lo = int'($urandom_range(0, 65535)) - 32768;
					hi = lo + int'($urandom_range(0, 200)) - 100;
					if (hi > 32767) hi = 32767;
					if (hi < -32768) hi = -32768; end
				default: begin lo = int'($urandom_range(0, 65535)) - 32768;
					hi = int'($urandom_range(0, 65535)) - 32768; end
			endcase
			set_range(lo, hi);
			for (int i = 0; i < PHASE_ITEMS; i++)
				height_queue.push_back(draw_height(lo, hi));
			if (p == 5 || p == 9) begin
				sender_calm = 1'b1;
				hold_request = 1'b1;
			end
		end

		drain();
		repeat (LATENCY) @(posedge clk);
		if (errors == 0 && color_expected.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/hgc_pkg.sv
sv/hgc_div_cell.sv
sv/hgc_blend.sv
sv/height_gradient_colormap_core.sv
sim/height_gradient_colormap_core_test.sv
